FILE: rtl/core/amix_pkg.sv
// ----------------------------------------------------------------------------
// amix_pkg
// Shared types, constants and codes of the audio mix accumulator.
// ----------------------------------------------------------------------------
package amix_pkg;

    localparam int BUFFER_FRAMES = 4096;
    localparam int CHANNELS      = 2;
    localparam int MIX_WORDS     = BUFFER_FRAMES * CHANNELS;

    // Memory address width and write position width (the position may
    // reach MIX_WORDS itself).
    localparam int ADDR_W = $clog2(MIX_WORDS);
    localparam int POS_W  = ADDR_W + 1;

    // Fixed field widths of the request and result items.
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 13;
    localparam int WORD_W   = 32;
    localparam int RATIO_W  = 4;
    // Word count of one mix request: up to two words per held frame.
    localparam int CNT_W    = RATIO_W + 1;

    // Stream data widths.
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 32;

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [OP_W-1:0] {
        OP_MIX   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_UP_RATIO       = 2'd0,
        REG_MONO_SOURCE    = 2'd1,
        REG_NARROW_SAMPLES = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    typedef struct packed {
        logic [RATIO_W-1:0] up_ratio;
        logic               mono_source;
        logic               narrow_samples;
    } cfg_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

endpackage

FILE: rtl/core/amix_ram.sv
// ----------------------------------------------------------------------------
// amix_ram
// Simple dual-port accumulator memory, one write and one registered read.
// ----------------------------------------------------------------------------
module amix_ram
    import amix_pkg::*;
(
    input  logic              aclk,
    input  ram_req_t          req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [MIX_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/amix_cfg.sv
// ----------------------------------------------------------------------------
// amix_cfg
// APB register bank holding the up-sampling ratio and the source format.
// ----------------------------------------------------------------------------
module amix_cfg
    import amix_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [RATIO_W-1:0] up_ratio_reg;
    logic               mono_reg;
    logic               narrow_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_ratio_reg <= RATIO_W'(1);
            mono_reg     <= 1'b0;
            narrow_reg   <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_UP_RATIO:       up_ratio_reg <= pwdata[RATIO_W-1:0];
                REG_MONO_SOURCE:    mono_reg     <= pwdata[0];
                REG_NARROW_SAMPLES: narrow_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_UP_RATIO:       prdata = APB_DW'(up_ratio_reg);
            REG_MONO_SOURCE:    prdata = APB_DW'(mono_reg);
            REG_NARROW_SAMPLES: prdata = APB_DW'(narrow_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.up_ratio       = up_ratio_reg;
    assign cfg.mono_source    = mono_reg;
    assign cfg.narrow_samples = narrow_reg;

endmodule

FILE: rtl/core/amix_seq.sv
// ----------------------------------------------------------------------------
// amix_seq
// Request sequencer: clearing sweep, read-modify-write mix loop, word reads
// and the result register.
// ----------------------------------------------------------------------------
module amix_seq
    import amix_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [OP_W-1:0]     s_op,
    input  logic                s_first,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic [INDEX_W-1:0]  s_read_index,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_mixed_word,
    output logic [INDEX_W-1:0]  m_word_index,
    output ram_req_t            ram_req,
    input  logic [WORD_W-1:0]   ram_rdata
);

    // Adds a sign-extended sample to a word, clamped to the 32-bit range.
    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] s);
        logic [WORD_W:0] sum;
        begin
            sum = {a[WORD_W-1], a} + {{(WORD_W-SAMPLE_W+1){s[SAMPLE_W-1]}}, s};
            if (sum[WORD_W] != sum[WORD_W-1]) begin
                sat_add = sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                      : {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                sat_add = sum[WORD_W-1:0];
            end
        end
    endfunction

    // Clamps a word to the signed 16-bit range.
    function automatic logic [SAMPLE_W-1:0] clamp16(input logic [WORD_W-1:0] w);
        logic [WORD_W-SAMPLE_W:0] top;
        begin
            top = w[WORD_W-1:SAMPLE_W-1];
            if ((&top) || !(|top)) begin
                clamp16 = w[SAMPLE_W-1:0];
            end else begin
                clamp16 = w[WORD_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
        end
    endfunction

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [POS_W-1:0]     wp_reg, wp_next;
    logic                 right_reg, right_next;
    logic [POS_W-1:0]     addr_reg, addr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 step2_reg, step2_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0]    p_addr_reg, p_addr_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]  m_word_reg, m_word_next;
    logic [INDEX_W-1:0]   m_index_reg, m_index_next;

    // Mix request set-up terms.
    logic [POS_W-1:0]     wp_eff;
    logic                 rp_eff;
    logic [POS_W:0]       wp_sum;
    logic [POS_W-1:0]     wp_adv;
    logic [SAMPLE_W-1:0]  dec_sample;
    logic                 addr_ok;

    always_comb begin
        wp_eff     = s_first ? '0 : wp_reg;
        rp_eff     = s_first ? 1'b0 : right_reg;
        wp_sum     = {1'b0, wp_eff} + (POS_W+1)'({cfg.up_ratio, 1'b0});
        wp_adv     = (wp_sum > (POS_W+1)'(MIX_WORDS)) ? POS_W'(MIX_WORDS)
                                                      : wp_sum[POS_W-1:0];
        dec_sample = cfg.narrow_samples
                   ? {{(SAMPLE_W-8){s_sample[7]}}, s_sample[7:0]} : s_sample;
        addr_ok    = addr_reg < POS_W'(MIX_WORDS);
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        wp_next      = wp_reg;
        right_next   = right_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        step2_next   = step2_reg;
        sample_next  = sample_reg;
        p_valid_next = 1'b0;
        p_addr_next  = p_addr_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        m_index_next = m_index_reg;
        s_tready     = 1'b0;
        ram_req      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Write-back half of the mix pipeline: the word read last cycle.
        if (p_valid_reg) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = p_addr_reg;
            ram_req.wdata = sat_add(ram_rdata, sample_reg);
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MIX_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (op_t'(s_op))
                        OP_MIX: begin
                            sample_next = dec_sample;
                            step2_next  = !cfg.mono_source;
                            addr_next   = wp_eff
                                        + POS_W'(!cfg.mono_source && rp_eff);
                            cnt_next    = cfg.mono_source
                                        ? {cfg.up_ratio, 1'b0}
                                        : CNT_W'(cfg.up_ratio);
                            state_next  = ST_MIX;
                            if (cfg.up_ratio == '0) begin
                                wp_next    = wp_eff;
                                right_next = rp_eff;
                            end else if (cfg.mono_source) begin
                                wp_next    = wp_adv;
                                right_next = 1'b0;
                            end else if (!rp_eff) begin
                                wp_next    = wp_eff;
                                right_next = 1'b1;
                            end else begin
                                wp_next    = wp_adv;
                                right_next = 1'b0;
                            end
                        end
                        OP_READ: begin
                            idx_next   = s_read_index;
                            state_next = ST_RD_ISSUE;
                        end
                        OP_CLEAR: begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MIX: begin
                // Read half: one word per cycle; words past the end are skipped.
                if (cnt_reg != '0) begin
                    ram_req.re    = addr_ok;
                    ram_req.raddr = addr_reg[ADDR_W-1:0];
                    p_valid_next  = addr_ok;
                    p_addr_next   = addr_reg[ADDR_W-1:0];
                    addr_next     = addr_reg + (step2_reg ? POS_W'(2) : POS_W'(1));
                    cnt_next      = cnt_reg - CNT_W'(1);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE: begin
                if (!m_valid_reg || m_tready) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(idx_reg);
                    state_next    = ST_RD_DATA;
                end
            end
            ST_RD_DATA: begin
                m_valid_next = 1'b1;
                m_word_next  = (32'(idx_reg) < 32'(MIX_WORDS)) ? clamp16(ram_rdata) : '0;
                m_index_next = idx_reg;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wp_reg      <= '0;
            right_reg   <= 1'b0;
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wp_reg      <= wp_next;
            right_reg   <= right_next;
            cnt_reg     <= cnt_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        step2_reg   <= step2_next;
        sample_reg  <= sample_next;
        p_addr_reg  <= p_addr_next;
        idx_reg     <= idx_next;
        m_word_reg  <= m_word_next;
        m_index_reg <= m_index_next;
    end

    assign m_tvalid     = m_valid_reg;
    assign m_mixed_word = m_word_reg;
    assign m_word_index = m_index_reg;

endmodule

FILE: rtl/core/audio_mix_accumulator.sv
// ----------------------------------------------------------------------------
// audio_mix_accumulator
// Saturating stereo mix accumulator with sample-hold up-sampling.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream; the request kind and the first-sample
// flag travel in s_tuser, the sample and the read index in s_tdata. A mix
// request adds one source sample, held for up_ratio frames, into an 8192-word
// accumulator memory of signed 32-bit words (left at even, right at odd
// addresses), saturating each sum. A read request returns one word clamped to
// 16 bits on the m_ stream; mix and clear requests return nothing.
// The memory has a single read and a single write port and every word goes
// through a read-modify-write: a mix request reads and writes back its word
// count (up_ratio words in stereo, twice that in mono). A read passes through
// ST_RD_ISSUE and ST_RD_DATA before its word is registered for m_tvalid.
// A clear request sweeps the memory one word a cycle; no request is taken
// during the sweep. After reset the same sweep runs before the first
// request is accepted; registers come up as up_ratio 1, stereo, 16-bit.
// A result waits in an output register while the receiver stalls; mix and
// clear requests go on meanwhile, and a read waits only for that register.
// Configuration goes through the APB port; the user must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module audio_mix_accumulator
    import amix_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // Request stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // sample[15:0], read_index[28:16], zero
    input  logic [S_USER_W-1:0] s_tuser,  // op[1:0], first[2]
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // mixed_word[15:0], word_index[28:16], zero
);

    cfg_t                cfg;
    ram_req_t            ram_req;
    logic [WORD_W-1:0]   ram_rdata;
    logic [SAMPLE_W-1:0] m_mixed_word;
    logic [INDEX_W-1:0]  m_word_index;

    amix_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: owns write position, the mix loop and the result register.
    amix_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_op         (s_tuser[OP_W-1:0]),
        .s_first      (s_tuser[OP_W]),
        .s_sample     (s_tdata[SAMPLE_W-1:0]),
        .s_read_index (s_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_mixed_word (m_mixed_word),
        .m_word_index (m_word_index),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    // The accumulator memory itself.
    amix_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign m_tdata = {{(M_DATA_W-SAMPLE_W-INDEX_W){1'b0}}, m_word_index, m_mixed_word};

endmodule

FILE: tb/amix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amix_checker
// Predicts the read results of the audio mix accumulator and checks them.
// ----------------------------------------------------------------------------
// Follows the APB writes and every accepted request. It keeps its own image of
// the accumulator memory, the write position and the channel phase. Each read
// request queues the clamped word that it should return. Each result on the
// m_ stream is compared with the oldest queued word.
// ----------------------------------------------------------------------------
module amix_checker
    import amix_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // sample[15:0], read_index[28:16], zero
    input  logic [S_USER_W-1:0] s_tuser,   // op[1:0], first[2]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // mixed_word[15:0], word_index[28:16], zero
    output int                  fail_count,
    output int                  reads_pending
);

    localparam longint WORD_MAX = (longint'(1) << 31) - 1;
    localparam longint WORD_MIN = -(longint'(1) << 31);
    localparam logic signed [WORD_W-1:0] CLAMP_HI = 32767;
    localparam logic signed [WORD_W-1:0] CLAMP_LO = -32768;

    typedef struct {
        logic [SAMPLE_W-1:0] word;
        logic [INDEX_W-1:0]  index;
    } read_result_t;

    logic signed [WORD_W-1:0] mix_image [MIX_WORDS];
    int unsigned              write_pos;
    logic                     right_phase;
    cfg_t                     cfg;
    read_result_t             expected_reads [$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ERROR %s: expected %0h, got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    task automatic accumulate(input int unsigned addr, input int sample);
        longint sum;
        if (addr < MIX_WORDS) begin
            sum = longint'(mix_image[addr]) + longint'(sample);
            if (sum > WORD_MAX) begin
                sum = WORD_MAX;
            end
            if (sum < WORD_MIN) begin
                sum = WORD_MIN;
            end
            mix_image[addr] = sum[WORD_W-1:0];
        end
    endtask

    task automatic mix_sample(input logic first, input logic [SAMPLE_W-1:0] raw);
        int          sample;
        int unsigned ratio;
        int unsigned pos;
        int unsigned lane;
        int unsigned k;
        if (cfg.narrow_samples) begin
            sample = int'($signed(raw[7:0]));
        end else begin
            sample = int'($signed(raw));
        end
        ratio = 32'(cfg.up_ratio);
        if (first) begin
            write_pos   = 0;
            right_phase = 1'b0;
        end
        if (ratio == 0) begin
            return;
        end
        pos = write_pos;
        if (cfg.mono_source) begin
            for (k = 0; k < ratio; k++) begin
                accumulate(pos + 2 * k, sample);
                accumulate(pos + 2 * k + 1, sample);
            end
            right_phase = 1'b0;
        end else begin
            // Left and right land in their own word of the same held frames.
            lane = right_phase ? 1 : 0;
            for (k = 0; k < ratio; k++) begin
                accumulate(pos + 2 * k + lane, sample);
            end
            if (!right_phase) begin
                right_phase = 1'b1;
                return;
            end
            right_phase = 1'b0;
        end
        pos = pos + 2 * ratio;
        write_pos = (pos > MIX_WORDS) ? MIX_WORDS : pos;
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_word(input logic signed [WORD_W-1:0] w);
        if (w > CLAMP_HI) begin
            return CLAMP_HI[SAMPLE_W-1:0];
        end
        if (w < CLAMP_LO) begin
            return CLAMP_LO[SAMPLE_W-1:0];
        end
        return w[SAMPLE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        read_result_t       want;
        logic [INDEX_W-1:0] idx;
        if (!aresetn) begin
            foreach (mix_image[i]) begin
                mix_image[i] = '0;
            end
            write_pos          = 0;
            right_phase        = 1'b0;
            cfg.up_ratio       = 4'd1;
            cfg.mono_source    = 1'b0;
            cfg.narrow_samples = 1'b0;
            expected_reads.delete();
            fail_count         = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_UP_RATIO:       cfg.up_ratio       = pwdata[RATIO_W-1:0];
                    REG_MONO_SOURCE:    cfg.mono_source    = pwdata[0];
                    REG_NARROW_SAMPLES: cfg.narrow_samples = pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("result with no read waiting", '0, m_tdata);
                end else begin
                    want = expected_reads.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want.word) begin
                        report_mismatch("mixed_word", 32'(want.word),
                                        32'(m_tdata[SAMPLE_W-1:0]));
                    end
                    if (m_tdata[SAMPLE_W +: INDEX_W] !== want.index) begin
                        report_mismatch("word_index", 32'(want.index),
                                        32'(m_tdata[SAMPLE_W +: INDEX_W]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (op_t'(s_tuser[OP_W-1:0]))
                    OP_MIX: mix_sample(s_tuser[OP_W], s_tdata[SAMPLE_W-1:0]);
                    OP_READ: begin
                        idx        = s_tdata[SAMPLE_W +: INDEX_W];
                        want.index = idx;
                        want.word  = (idx < MIX_WORDS) ? clamp_word(mix_image[idx]) : '0;
                        expected_reads.push_back(want);
                    end
                    OP_CLEAR: begin
                        foreach (mix_image[i]) begin
                            mix_image[i] = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        reads_pending <= expected_reads.size();
    end

endmodule

FILE: tb/tb_audio_mix_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_mix_accumulator
// Directed and random regression of the audio mix accumulator.
// ----------------------------------------------------------------------------
// A directed part covers clamping at both ends, ratio zero, the largest ratio
// in mono 8-bit mode, the unused request kind and a clear. Then random phases
// run, each with its own register setting: sources start with a first-sample
// request followed by a run of mix requests, interleaved with reads near the
// written area, and a little noise (clears, unused kinds). One phase runs a
// single long mono source so that the write position hits the end of memory.
// The checker beside the block predicts every read; this module only drives.
// ----------------------------------------------------------------------------
module tb_audio_mix_accumulator;
    import amix_pkg::*;

    // A clear takes a full memory sweep, so the limit is far above any correct run.
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;
    // A mix of the largest ratio in mono touches 30 words.
    localparam int unsigned SETTLE_CYCLES = 48;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int          fail_count;
    int          reads_pending;
    int unsigned cycle_count = 0;
    // Percentage of requests preceded by a gap, and of cycles that start a
    // receiver stall. Zero gives a stretch without any idling.
    int unsigned gap_pct     = 0;
    int unsigned stall_left  = 0;
    // Rough idea of where the current source writes, used to aim reads.
    int unsigned cur_ratio   = 1;
    logic        cur_mono    = 1'b0;
    int unsigned pos_hint    = 0;

    always #10 aclk = ~aclk;

    audio_mix_accumulator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    amix_checker u_mix_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .reads_pending (reads_pending)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side: stalls come in bursts.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // One register write: setup phase, then access phase until pready. The bus
    // is then left idle so that back-to-back writes never assign psel twice in
    // one time step.
    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_mode(input int unsigned ratio, input logic mono, input logic narrow);
        apb_write(REG_UP_RATIO, ratio);
        apb_write(REG_MONO_SOURCE, APB_DW'(mono));
        apb_write(REG_NARROW_SAMPLES, APB_DW'(narrow));
        cur_ratio = ratio;
        cur_mono  = mono;
    endtask

    // Offers one request and returns at the edge where it is accepted. A gap
    // before it lowers tvalid; otherwise tvalid stays high from the last one.
    task automatic send_req(input logic [OP_W-1:0] op, input logic first,
                            input logic [SAMPLE_W-1:0] sample,
                            input logic [INDEX_W-1:0] index);
        int unsigned gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 5);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {first, op};
        s_tdata  <= S_DATA_W'({index, sample});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits until every read has returned, then lets a trailing mix finish
    // before registers may be touched again.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reads_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A random single bit for flags and modes.
    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Samples lean toward the extremes of both widths. A loud source keeps
    // one sign so that repeated sources push words past the 16-bit range.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned loudness);
        logic [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v[7:0] = 8'h7F;
            3: v[7:0] = 8'h80;
            default: ;
        endcase
        if (loudness == 1) begin
            v[15:12] = 4'h7;
            v[7:6]   = 2'b01;
        end else if (loudness == 2) begin
            v[15:12] = 4'h8;
            v[7:6]   = 2'b10;
        end
        return v;
    endfunction

    // Most reads look at the area the current source has reached; the rest
    // go anywhere or to the last words of memory.
    function automatic logic [INDEX_W-1:0] pick_index();
        int unsigned r;
        int unsigned upper;
        r = $urandom_range(0, 99);
        upper = pos_hint + 2 * cur_ratio + 4;
        if (upper > MIX_WORDS - 1) begin
            upper = MIX_WORDS - 1;
        end
        if (r < 70) begin
            return INDEX_W'($urandom_range(0, upper));
        end
        if (r < 85) begin
            return INDEX_W'($urandom_range(0, MIX_WORDS - 1));
        end
        return INDEX_W'($urandom_range(MIX_WORDS - 16, MIX_WORDS - 1));
    endfunction

    // One random phase. A max_len above 64 means one source of exactly that
    // length. The phase closes with a read so that the block ends up idle.
    task automatic run_phase(input int unsigned n_items, input int unsigned max_len,
                             input int unsigned read_pct);
        int unsigned i;
        int unsigned r;
        int unsigned left;
        int unsigned loudness;
        logic        first;
        left     = 0;
        loudness = 0;
        for (i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r == 0) begin
                send_req(OP_CLEAR, rand_bit(), pick_sample(0), pick_index());
            end else if (r < 3) begin
                send_req(OP_UNUSED, rand_bit(), pick_sample(0), pick_index());
            end else if (r < 3 + read_pct) begin
                send_req(OP_READ, rand_bit(), pick_sample(0), pick_index());
            end else begin
                first = 1'b0;
                if (left == 0) begin
                    left     = (max_len > 64) ? max_len : $urandom_range(1, max_len);
                    loudness = $urandom_range(0, 2);
                    first    = 1'b1;
                    pos_hint = 0;
                end
                send_req(OP_MIX, first, pick_sample(loudness),
                         INDEX_W'($urandom_range(0, 8191)));
                left--;
                pos_hint += cur_mono ? 2 * cur_ratio : cur_ratio;
                if (pos_hint > MIX_WORDS) begin
                    pos_hint = MIX_WORDS;
                end
            end
        end
        send_req(OP_READ, rand_bit(), pick_sample(0), pick_index());
        drain_pipeline();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // The first request waits out the clearing sweep after reset; its
        // read doubles as proof that the block is idle before configuration.
        send_req(OP_READ, 1'b0, 16'h0000, 13'd0);
        drain_pipeline();
        set_mode(1, 1'b0, 1'b0);

        // Two stereo sources of full-scale positive samples on the same
        // frame: both words sum past the 16-bit range and clamp high.
        send_req(OP_MIX, 1'b1, 16'h7FFF, 13'h1FFF);
        send_req(OP_MIX, 1'b0, 16'h7FFF, 13'h0000);
        send_req(OP_MIX, 1'b1, 16'h7FFF, 13'h1555);
        send_req(OP_MIX, 1'b0, 16'h7FFF, 13'h0AAA);
        send_req(OP_READ, 1'b0, 16'hFFFF, 13'd0);
        send_req(OP_READ, 1'b1, 16'h0000, 13'd1);
        // After a clear, the same with full-scale negative samples clamps low.
        send_req(OP_CLEAR, 1'b0, 16'h5555, 13'h0555);
        send_req(OP_MIX, 1'b1, 16'h8000, 13'd0);
        send_req(OP_MIX, 1'b0, 16'h8000, 13'd0);
        send_req(OP_MIX, 1'b1, 16'h8000, 13'd0);
        send_req(OP_MIX, 1'b0, 16'h8000, 13'd0);
        send_req(OP_READ, 1'b0, 16'h0000, 13'd0);
        send_req(OP_READ, 1'b0, 16'h0000, 13'h1FFF);
        // The unused kind must not restart the position even with first set.
        send_req(OP_UNUSED, 1'b1, 16'hAAAA, 13'h1AAA);
        send_req(OP_READ, 1'b0, 16'h0000, 13'd1);
        drain_pipeline();

        // Ratio zero: the first flag still restarts, but nothing is written.
        set_mode(0, 1'b1, 1'b1);
        send_req(OP_MIX, 1'b1, 16'h5A7F, 13'd0);
        send_req(OP_READ, 1'b0, 16'h0000, 13'd0);
        drain_pipeline();

        // Largest ratio, mono, 8-bit: the high byte must be ignored.
        set_mode(15, 1'b1, 1'b1);
        send_req(OP_MIX, 1'b1, 16'hFF80, 13'd0);
        send_req(OP_MIX, 1'b0, 16'h017F, 13'd0);
        send_req(OP_READ, 1'b0, 16'h0000, 13'd29);
        send_req(OP_READ, 1'b0, 16'h0000, 13'd30);
        send_req(OP_READ, 1'b0, 16'h0000, 13'd60);
        drain_pipeline();

        gap_pct = 15;
        set_mode(1, 1'b0, 1'b0);
        run_phase(130, 40, 25);
        gap_pct = 35;
        set_mode(12, 1'b1, 1'b0);
        run_phase(130, 20, 25);
        gap_pct = 0;
        set_mode(6, 1'b0, 1'b1);
        run_phase(130, 30, 25);
        // One long source runs the write position into the end of memory.
        gap_pct = 10;
        set_mode(15, 1'b1, 1'b1);
        run_phase(330, 1000, 12);
        gap_pct = 20;
        set_mode(0, 1'b0, 1'b0);
        run_phase(60, 10, 25);
        gap_pct = 30;
        set_mode(3, 1'b1, 1'b1);
        run_phase(130, 40, 25);
        gap_pct = 15;
        set_mode(14, 1'b0, 1'b0);
        run_phase(130, 30, 25);
        gap_pct = 25;
        set_mode($urandom_range(1, 15), rand_bit(), rand_bit());
        run_phase(130, 30, 25);

        // Final stretch runs at full rate on both sides.
        gap_pct = 0;
        set_mode($urandom_range(1, 15), rand_bit(), rand_bit());
        run_phase(130, 30, 25);
        set_mode($urandom_range(1, 15), rand_bit(), rand_bit());
        run_phase(130, 30, 25);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
